@@ hdl/lav_pkg.sv @@
// shared constants and types of the look-at view matrix unit
`timescale 1ns / 1ps

package lav_pkg;

   localparam int CROSS_LAT   = 2;
   localparam int SHIFT_STEPS = 6;
   localparam int ALIGN_LAT   = SHIFT_STEPS + 2;
   localparam int SQRT_LAT    = 31;
   localparam int Q_W         = 17;
   localparam int DIV_LAT     = Q_W + 1;

   localparam int WORD_W = 32;
   localparam int RAW_W  = 65;
   localparam int MAG_W  = 30;
   localparam int SUM_W  = 2 * SQRT_LAT;
   localparam int LEN_W  = SQRT_LAT;
   localparam int ROW_W  = 18;

   localparam logic [Q_W-1:0] Q_ONE = 17'h10000;

   typedef logic [2:0][WORD_W-1:0] word_vec_type;
   typedef logic [2:0][RAW_W-1:0]  raw_vec_type;

   typedef struct packed {
      logic [2:0]             sign;
      logic [2:0][MAG_W-1:0]  mag;
      word_vec_type           val;
   } aligned_vec_type;

endpackage

@@ hdl/lav_delay.sv @@
// enabled delay line for payload that rides beside the arithmetic
`timescale 1ns / 1ps

module lav_delay #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1
) (
   input  logic             clock,
   input  logic             en,
   input  logic [WIDTH-1:0] din,
   output logic [WIDTH-1:0] dout
);

   logic [WIDTH-1:0] line_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (en) begin
         line_ff[0] <= din;
         for (int i = 1; i < DEPTH; i++) begin
            line_ff[i] <= line_ff[i-1];
         end
      end
   end

   assign dout = line_ff[DEPTH-1];

endmodule

@@ hdl/lav_cross.sv @@
// two-stage cross product of signed 32-bit vectors
`timescale 1ns / 1ps

module lav_cross (
   input  logic                  clock,
   input  logic                  en,
   input  lav_pkg::word_vec_type a,
   input  lav_pkg::word_vec_type b,
   output lav_pkg::raw_vec_type  prod
);

   logic signed [63:0] prod_in [6];
   logic signed [63:0] prod_ff [6];
   lav_pkg::raw_vec_type res_ff;

   assign prod_in[0] = $signed(a[1]) * $signed(b[2]);
   assign prod_in[1] = $signed(a[2]) * $signed(b[1]);
   assign prod_in[2] = $signed(a[2]) * $signed(b[0]);
   assign prod_in[3] = $signed(a[0]) * $signed(b[2]);
   assign prod_in[4] = $signed(a[0]) * $signed(b[1]);
   assign prod_in[5] = $signed(a[1]) * $signed(b[0]);

   always_ff @(posedge clock) begin
      if (en) begin
         for (int j = 0; j < 6; j++) begin
            prod_ff[j] <= prod_in[j];
         end
         for (int i = 0; i < 3; i++) begin
            res_ff[i] <= {prod_ff[2*i][63], prod_ff[2*i]} -
                         {prod_ff[2*i+1][63], prod_ff[2*i+1]};
         end
      end
   end

   assign prod = res_ff;

endmodule

@@ hdl/lav_align.sv @@
// block alignment: common shift that puts the largest magnitude at bit 29
`timescale 1ns / 1ps

module lav_align (
   input  logic                     clock,
   input  logic                     en,
   input  lav_pkg::raw_vec_type     v,
   output lav_pkg::aligned_vec_type aligned
);

   localparam int STEPS = lav_pkg::SHIFT_STEPS;
   localparam int MW    = lav_pkg::MAG_W;

   logic [2:0][63:0] mag_in;
   logic [2:0][63:0] mag_ff;
   logic [2:0]       sign_ff;
   logic [2:0][63:0] step_mag_ff  [STEPS];
   logic [2:0]       step_sign_ff [STEPS];
   lav_pkg::aligned_vec_type out_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         mag_in[i] = v[i][64] ? (~v[i][63:0] + 64'd1) : v[i][63:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mag_ff <= mag_in;
         for (int i = 0; i < 3; i++) begin
            sign_ff[i] <= v[i][64];
         end
      end
   end

   // the or of the magnitudes has the same leading one as their maximum
   for (genvar j = 0; j < STEPS; j++) begin : g_step
      localparam int SH = 1 << (STEPS - 1 - j);
      logic [2:0][63:0] cur;
      logic [2:0]       cur_sign;
      logic [63:0]      lead;

      if (j == 0) begin : g_first
         assign cur      = mag_ff;
         assign cur_sign = sign_ff;
      end else begin : g_next
         assign cur      = step_mag_ff[j-1];
         assign cur_sign = step_sign_ff[j-1];
      end

      assign lead = cur[0] | cur[1] | cur[2];

      always_ff @(posedge clock) begin
         if (en) begin
            step_sign_ff[j] <= cur_sign;
            for (int i = 0; i < 3; i++) begin
               step_mag_ff[j][i] <= (lead[63 -: SH] == '0) ? (cur[i] << SH) : cur[i];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         out_ff.sign <= step_sign_ff[STEPS-1];
         for (int i = 0; i < 3; i++) begin
            out_ff.mag[i] <= step_mag_ff[STEPS-1][i][63 -: MW];
            out_ff.val[i] <= step_sign_ff[STEPS-1][i] ?
                             -{2'b00, step_mag_ff[STEPS-1][i][63 -: MW]} :
                             {2'b00, step_mag_ff[STEPS-1][i][63 -: MW]};
         end
      end
   end

   assign aligned = out_ff;

endmodule

@@ hdl/lav_sqrt.sv @@
// pipelined integer square root, one result bit per stage
`timescale 1ns / 1ps

module lav_sqrt (
   input  logic                        clock,
   input  logic                        en,
   input  logic [lav_pkg::SUM_W-1:0]   radicand,
   output logic [lav_pkg::LEN_W-1:0]   root
);

   localparam int N  = lav_pkg::SQRT_LAT;
   localparam int XW = lav_pkg::SUM_W;
   localparam int RW = lav_pkg::LEN_W;

   logic [XW-1:0] x_ff    [N-1];
   logic [RW+1:0] rem_ff  [N];
   logic [RW-1:0] root_ff [N];

   for (genvar j = 0; j < N; j++) begin : g_stage
      logic [XW-1:0] x_cur;
      logic [RW+1:0] rem_cur;
      logic [RW-1:0] root_cur;
      logic [RW+3:0] acc;
      logic [RW+3:0] trial;

      if (j == 0) begin : g_first
         assign x_cur    = radicand;
         assign rem_cur  = '0;
         assign root_cur = '0;
      end else begin : g_next
         assign x_cur    = x_ff[j-1];
         assign rem_cur  = rem_ff[j-1];
         assign root_cur = root_ff[j-1];
      end

      assign acc   = {rem_cur, x_cur[XW-1 -: 2]};
      assign trial = {2'b00, root_cur, 2'b01};

      if (j < N - 1) begin : g_x
         always_ff @(posedge clock) begin
            if (en) begin
               x_ff[j] <= {x_cur[XW-3:0], 2'b00};
            end
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            if (acc >= trial) begin
               rem_ff[j]  <= acc[RW+1:0] - trial[RW+1:0];
               root_ff[j] <= {root_cur[RW-2:0], 1'b1};
            end else begin
               rem_ff[j]  <= acc[RW+1:0];
               root_ff[j] <= {root_cur[RW-2:0], 1'b0};
            end
         end
      end
   end

   assign root = root_ff[N-1];

endmodule

@@ hdl/lav_div.sv @@
// pipelined rounded divide |c| * 2^16 / len, one quotient bit per stage
`timescale 1ns / 1ps

module lav_div (
   input  logic                       clock,
   input  logic                       en,
   input  logic [lav_pkg::MAG_W-1:0]  mag,
   input  logic [lav_pkg::LEN_W-1:0]  len,
   output logic [lav_pkg::Q_W-1:0]    quot
);

   localparam int QW = lav_pkg::Q_W;
   localparam int LW = lav_pkg::LEN_W;
   localparam int NW = lav_pkg::MAG_W + QW;

   logic [NW-1:0] num_ff;
   logic [LW-1:0] len0_ff;
   logic [NW-1:0] rem_ff [QW-1];
   logic [LW-1:0] len_ff [QW-1];
   logic [QW-1:0] q_ff   [QW];

   // half the length is added for round to nearest
   always_ff @(posedge clock) begin
      if (en) begin
         num_ff  <= {1'b0, mag, 16'h0000} + {17'h00000, len[LW-1:1]};
         len0_ff <= len;
      end
   end

   for (genvar s = 0; s < QW; s++) begin : g_step
      localparam int K = QW - 1 - s;
      logic [NW-1:0] rem_cur;
      logic [LW-1:0] len_cur;
      logic [QW-1:0] q_cur;
      logic [QW-1:0] q_set;
      logic [NW:0]   den;
      logic          take;

      if (s == 0) begin : g_first
         assign rem_cur = num_ff;
         assign len_cur = len0_ff;
         assign q_cur   = '0;
      end else begin : g_next
         assign rem_cur = rem_ff[s-1];
         assign len_cur = len_ff[s-1];
         assign q_cur   = q_ff[s-1];
      end

      assign den  = 48'(len_cur) << K;
      assign take = ({1'b0, rem_cur} >= den);

      always_comb begin
         q_set    = q_cur;
         q_set[K] = take;
      end

      if (s < QW - 1) begin : g_rem
         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[s] <= take ? (rem_cur - den[NW-1:0]) : rem_cur;
               len_ff[s] <= len_cur;
            end
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            q_ff[s] <= q_set;
         end
      end
   end

   assign quot = q_ff[QW-1];

endmodule

@@ hdl/look_at_view_matrix_unit.sv @@
// look-at view matrix unit: 3x4 camera matrix from position, direction and up
// throughput: one word per cycle; the 31-stage square root and 18-stage divider
//    set the depth, every stage takes a new word when the output side moves
// a single pipeline enable holds every stage while the response word waits
// reset clears the stage valid bits only; payload registers are not reset
`timescale 1ns / 1ps

module look_at_view_matrix_unit (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // pos_x, pos_y, pos_z, dir_x, dir_y, dir_z, upin_x, upin_y, upin_z (32 bits each)
   input  logic [287:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // right_x, right_y, right_z (18), right_shift (32), upout_x, upout_y, upout_z (18),
   // up_shift (32), back_x, back_y, back_z (18), back_shift (32), 6 zero bits
   output logic [263:0] rsp_tdata
);

   // stage numbers, each the register stage where that value lands
   localparam int ST_IN   = 1;
   localparam int ST_RRAW = ST_IN + lav_pkg::CROSS_LAT;
   localparam int ST_A1   = ST_RRAW + lav_pkg::ALIGN_LAT;
   localparam int ST_URAW = ST_A1 + lav_pkg::CROSS_LAT;
   localparam int ST_A2   = ST_URAW + lav_pkg::ALIGN_LAT;
   localparam int ST_SQ   = ST_A2 + 1;
   localparam int ST_SUM  = ST_SQ + 1;
   localparam int ST_LEN  = ST_SUM + lav_pkg::SQRT_LAT;
   localparam int ST_Q    = ST_LEN + lav_pkg::DIV_LAT;
   localparam int ST_ROW  = ST_Q + 1;
   localparam int ST_PROD = ST_ROW + 1;
   localparam int ST_DOT  = ST_PROD + 1;
   localparam int ST_OUT  = ST_DOT + 1;

   localparam int MW = lav_pkg::MAG_W;
   localparam int RW = lav_pkg::ROW_W;
   localparam int QW = lav_pkg::Q_W;

   logic en;
   logic [ST_OUT:ST_IN] valid_ff;

   lav_pkg::word_vec_type pos_ff, dir_ff, upin_ff;
   lav_pkg::word_vec_type dir_d, pos_d;
   lav_pkg::raw_vec_type  rraw, dir_raw, uraw;
   lav_pkg::aligned_vec_type ra, da, ua, ra_d, da_d;
   lav_pkg::aligned_vec_type row_vec [3];

   wire [2:0][2:0][RW-1:0] rot_all;
   wire [2:0][2:0][QW-1:0] q_all;
   wire [2:0]              zero_all;
   logic [2:0][2:0][RW-1:0] rot_out;

   logic signed [49:0] prod_ff [3][3];
   logic signed [51:0] dot_ff  [3];
   logic [2:0][31:0]   shift_in;
   logic [2:0][31:0]   shift_ff;
   logic               q_in_range;

   // the whole pipeline advances unless a finished word is held at the output
   assign en         = !rsp_tvalid || rsp_tready;
   assign req_tready = en;
   assign rsp_tvalid = valid_ff[ST_OUT];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[ST_OUT-1:ST_IN], req_tvalid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            pos_ff[i]  <= req_tdata[32*i +: 32];
            dir_ff[i]  <= req_tdata[96 + 32*i +: 32];
            upin_ff[i] <= req_tdata[192 + 32*i +: 32];
         end
      end
   end

   // right = dir x upin, exact
   lav_cross u_cross_right (
      .clock (clock), .en (en), .a (dir_ff), .b (upin_ff), .prod (rraw)
   );

   lav_delay #(.WIDTH (96), .DEPTH (ST_RRAW - ST_IN)) u_dly_dir (
      .clock (clock), .en (en), .din (dir_ff), .dout (dir_d)
   );

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         dir_raw[i] = {{33{dir_d[i][31]}}, dir_d[i]};
      end
   end

   // aligned right and dir serve both the up cross product and normalization
   lav_align u_align_right (.clock (clock), .en (en), .v (rraw),    .aligned (ra));
   lav_align u_align_dir   (.clock (clock), .en (en), .v (dir_raw), .aligned (da));

   // up = aligned right x aligned dir
   lav_cross u_cross_up (
      .clock (clock), .en (en), .a (ra.val), .b (da.val), .prod (uraw)
   );

   lav_align u_align_up (.clock (clock), .en (en), .v (uraw), .aligned (ua));

   lav_delay #(.WIDTH ($bits(lav_pkg::aligned_vec_type)), .DEPTH (ST_A2 - ST_A1)) u_dly_ra (
      .clock (clock), .en (en), .din (ra), .dout (ra_d)
   );

   lav_delay #(.WIDTH ($bits(lav_pkg::aligned_vec_type)), .DEPTH (ST_A2 - ST_A1)) u_dly_da (
      .clock (clock), .en (en), .din (da), .dout (da_d)
   );

   assign row_vec[0] = ra_d;
   assign row_vec[1] = ua;
   assign row_vec[2] = da_d;

   // per row: sum of squares, square root, three rounded divides, sign
   for (genvar r = 0; r < 3; r++) begin : g_row
      localparam logic FLIP = (r == 2);
      logic [2:0][59:0] sq_ff;
      logic             zero_sq_ff;
      logic [lav_pkg::SUM_W-1:0] sum_ff;
      logic [lav_pkg::LEN_W-1:0] len;
      logic [2:0][MW-1:0] mag_d;
      logic [2:0]         sign_d;
      logic               zero_d;
      logic [2:0][QW-1:0] quot;
      logic [2:0][RW-1:0] rot_row_ff;

      always_ff @(posedge clock) begin
         if (en) begin
            for (int i = 0; i < 3; i++) begin
               sq_ff[i] <= row_vec[r].mag[i] * row_vec[r].mag[i];
            end
            zero_sq_ff <= ~|row_vec[r].mag;
            sum_ff     <= 62'(sq_ff[0]) + 62'(sq_ff[1]) + 62'(sq_ff[2]);
         end
      end

      lav_sqrt u_sqrt (.clock (clock), .en (en), .radicand (sum_ff), .root (len));

      lav_delay #(.WIDTH (3 * MW), .DEPTH (ST_LEN - ST_A2)) u_dly_mag (
         .clock (clock), .en (en), .din (row_vec[r].mag), .dout (mag_d)
      );

      lav_delay #(.WIDTH (3), .DEPTH (ST_Q - ST_A2)) u_dly_sign (
         .clock (clock), .en (en), .din (row_vec[r].sign), .dout (sign_d)
      );

      lav_delay #(.WIDTH (1), .DEPTH (ST_Q - ST_SQ)) u_dly_zero (
         .clock (clock), .en (en), .din (zero_sq_ff), .dout (zero_d)
      );

      for (genvar i = 0; i < 3; i++) begin : g_comp
         lav_div u_div (
            .clock (clock), .en (en), .mag (mag_d[i]), .len (len), .quot (quot[i])
         );
      end

      // zero-length vector gives zeros; back row takes the opposite sign
      always_ff @(posedge clock) begin
         if (en) begin
            for (int i = 0; i < 3; i++) begin
               if (zero_d) begin
                  rot_row_ff[i] <= '0;
               end else if (sign_d[i] ^ FLIP) begin
                  rot_row_ff[i] <= -{1'b0, quot[i]};
               end else begin
                  rot_row_ff[i] <= {1'b0, quot[i]};
               end
            end
         end
      end

      assign rot_all[r]  = rot_row_ff;
      assign q_all[r]    = quot;
      assign zero_all[r] = zero_d;
   end

   lav_delay #(.WIDTH (96), .DEPTH (ST_ROW - ST_IN)) u_dly_pos (
      .clock (clock), .en (en), .din (pos_ff), .dout (pos_d)
   );

   lav_delay #(.WIDTH (9 * RW), .DEPTH (ST_OUT - ST_ROW)) u_dly_rot (
      .clock (clock), .en (en), .din (rot_all), .dout (rot_out)
   );

   // translation: -(row . pos) plus half an lsb, then floor and saturate to q15.16
   always_ff @(posedge clock) begin
      if (en) begin
         for (int r = 0; r < 3; r++) begin
            for (int i = 0; i < 3; i++) begin
               prod_ff[r][i] <= $signed(rot_all[r][i]) * $signed(pos_d[i]);
            end
            dot_ff[r] <= 52'sd32768 - (52'(prod_ff[r][0]) + 52'(prod_ff[r][1]) +
                                       52'(prod_ff[r][2]));
         end
      end
   end

   always_comb begin
      logic [35:0] shr;
      shr = '0;
      for (int r = 0; r < 3; r++) begin
         shr = dot_ff[r][51:16];
         if (shr[35:31] == {5{shr[31]}}) begin
            shift_in[r] = shr[31:0];
         end else if (shr[35]) begin
            shift_in[r] = 32'h8000_0000;
         end else begin
            shift_in[r] = 32'h7FFF_FFFF;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         shift_ff <= shift_in;
      end
   end

   assign rsp_tdata = {6'b000000,
                       shift_ff[2], rot_out[2][2], rot_out[2][1], rot_out[2][0],
                       shift_ff[1], rot_out[1][2], rot_out[1][1], rot_out[1][0],
                       shift_ff[0], rot_out[0][2], rot_out[0][1], rot_out[0][0]};

   always_comb begin
      q_in_range = 1'b1;
      for (int r = 0; r < 3; r++) begin
         for (int i = 0; i < 3; i++) begin
            if (!zero_all[r] && (q_all[r][i] > lav_pkg::Q_ONE)) begin
               q_in_range = 1'b0;
            end
         end
      end
   end

   // a nonzero aligned right vector has its largest magnitude at bit 29
   a_right_aligned: assert property (@(posedge clock) disable iff (reset)
      valid_ff[ST_A1] && (|ra.mag) |->
         (ra.mag[0][MW-1] || ra.mag[1][MW-1] || ra.mag[2][MW-1]))
      else $error("right vector not aligned");

   // same for the recomputed up vector
   a_up_aligned: assert property (@(posedge clock) disable iff (reset)
      valid_ff[ST_A2] && (|ua.mag) |->
         (ua.mag[0][MW-1] || ua.mag[1][MW-1] || ua.mag[2][MW-1]))
      else $error("up vector not aligned");

   // a unit component never exceeds one in q1.16
   a_quot_range: assert property (@(posedge clock) disable iff (reset)
      valid_ff[ST_Q] |-> q_in_range)
      else $error("normalized component above one");

endmodule
